>>> rtl/core/rcm_pkg.sv
// shared types and constants of the rgba color matrix
package rcm_pkg;

	// pixel channels and matrix shape
	localparam int CHAN_W    = 8;
	localparam int ROWS      = 4;
	localparam int NUM_TERMS = 5;
	localparam int REG_W     = 60;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;

	// constant channel fed to the last matrix column
	localparam logic [CHAN_W-1:0] BIAS_CHAN = 8'd255;
	localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RED_ROW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_ROW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLUE_ROW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ROW = 3'd3;

	// one rgba pixel
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pix_t;

endpackage

>>> rtl/core/rcm_ifs.sv
// stream and configuration interfaces of the rgba color matrix

// source pixel channel
interface rcm_pix_in_if;
	logic                      valid;
	logic                      ready;
	logic [rcm_pkg::CHAN_W-1:0] red_in;
	logic [rcm_pkg::CHAN_W-1:0] green_in;
	logic [rcm_pkg::CHAN_W-1:0] blue_in;
	logic [rcm_pkg::CHAN_W-1:0] alpha_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// result pixel channel
interface rcm_pix_out_if;
	logic                      valid;
	logic                      ready;
	logic [rcm_pkg::CHAN_W-1:0] red_out;
	logic [rcm_pkg::CHAN_W-1:0] green_out;
	logic [rcm_pkg::CHAN_W-1:0] blue_out;
	logic [rcm_pkg::CHAN_W-1:0] alpha_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// register write channel
interface rcm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rcm_pkg::CFG_IDX_W-1:0]  index;
	logic [rcm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/rcm_cell.sv
// one matrix column cell: adds its column term to four running row sums
module rcm_cell #(
	parameter int COEF_WIDTH = 12,
	parameter int SUM_W      = 23,
	parameter int TERM       = 0
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          up_valid,
	output logic                                          up_ready,
	input  rcm_pkg::pix_t                                 pix_up,
	input  logic [rcm_pkg::ROWS-1:0][SUM_W-1:0]           sum_up,
	input  logic [rcm_pkg::ROWS-1:0][COEF_WIDTH-1:0]      coef,
	input  logic                                          dn_ready,
	output logic                                          dn_valid,
	output rcm_pkg::pix_t                                 pix_dn,
	output logic [rcm_pkg::ROWS-1:0][SUM_W-1:0]           sum_dn
);

	localparam int PROD_W = COEF_WIDTH + rcm_pkg::CHAN_W + 1;

	logic                                valid_s1;
	rcm_pkg::pix_t                       pix_s1;
	logic [rcm_pkg::ROWS-1:0][SUM_W-1:0] sum_s1;
	logic [rcm_pkg::CHAN_W-1:0]          chan;
	logic [rcm_pkg::ROWS-1:0][SUM_W-1:0] sum_next;
	logic                                advance;

	// stage takes a transfer when empty or when it drains this cycle
	assign advance  = !valid_s1 || dn_ready;
	assign up_ready = advance;

	// channel this column multiplies
	always_comb begin
		case (TERM)
			0: chan = pix_up.red;
			1: chan = pix_up.green;
			2: chan = pix_up.blue;
			3: chan = pix_up.alpha;
			default: chan = rcm_pkg::BIAS_CHAN;
		endcase
	end

	// one small multiply and add per row
	always_comb begin
		logic signed [PROD_W-1:0] prod;
		prod = '0;
		for (int r = 0; r < rcm_pkg::ROWS; r++) begin
			prod = PROD_W'($signed(coef[r]) * $signed({1'b0, chan}));
			sum_next[r] = SUM_W'($signed(sum_up[r]) + $signed(prod));
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= up_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (advance && up_valid) begin
			pix_s1 <= pix_up;
			sum_s1 <= sum_next;
		end
	end

	assign dn_valid = valid_s1;
	assign pix_dn   = pix_s1;
	assign sum_dn   = sum_s1;

endmodule

>>> rtl/core/rcm_clamp.sv
// output stage: clamps the row sums, drops the fraction, holds the result
module rcm_clamp #(
	parameter int SUM_W          = 23,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_ready,
	input  logic [rcm_pkg::ROWS-1:0][SUM_W-1:0] sum_up,
	rcm_pix_out_if.source                       pix_out
);

	localparam int WHOLE_W = SUM_W - COEF_FRAC_BITS;

	logic                                         valid_q;
	logic [rcm_pkg::ROWS-1:0][rcm_pkg::CHAN_W-1:0] chan_q;
	logic [rcm_pkg::ROWS-1:0][rcm_pkg::CHAN_W-1:0] chan_next;
	logic                                         advance;

	assign advance  = !valid_q || pix_out.ready;
	assign up_ready = advance;

	// negative or zero goes to 0, 256.0 and above to 255, else floor
	always_comb begin
		logic signed [SUM_W-1:0]   s;
		logic        [WHOLE_W-1:0] whole;
		s = '0;
		whole = '0;
		for (int r = 0; r < rcm_pkg::ROWS; r++) begin
			s = $signed(sum_up[r]);
			whole = WHOLE_W'(s >>> COEF_FRAC_BITS);
			if (s <= 0) begin
				chan_next[r] = '0;
			end else if (whole > WHOLE_W'(rcm_pkg::CHAN_MAX)) begin
				chan_next[r] = rcm_pkg::CHAN_MAX;
			end else begin
				chan_next[r] = whole[rcm_pkg::CHAN_W-1:0];
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && up_valid) begin
			chan_q <= chan_next;
		end
	end

	assign pix_out.valid     = valid_q;
	assign pix_out.red_out   = chan_q[0];
	assign pix_out.green_out = chan_q[1];
	assign pix_out.blue_out  = chan_q[2];
	assign pix_out.alpha_out = chan_q[3];

endmodule

>>> rtl/core/rgba_color_matrix_core.sv
// top level of the rgba 4x5 color matrix
//
// pix_in carries one rgba source pixel per transfer, pix_out one result pixel
// per transfer; both use valid/ready. cfg writes one 60-bit row register per
// transfer: index 0..3 selects red, green, blue or alpha row, other indexes are
// dropped. cfg is always ready. Write rows only while no pixel is in flight.
// Each row holds five signed coefficients, field k at bits COEF_WIDTH*k up,
// applied to R, G, B, A and the constant 255.
// The datapath is a row of five column cells, one per matrix column, each
// adding its term to all four row sums, then a clamp stage with the output
// register. Data passes the five cell registers, then the output register;
// one pixel in and one out every cycle when the receiver keeps ready high.
// Reset loads the identity matrix and empties every stage.
// When the receiver stalls, results stay in the output register and cells;
// empty cells still take pixels until the chain is full, then pix_in.ready
// drops until the receiver takes a result.
module rgba_color_matrix_core #(
	parameter int COEF_WIDTH     = 12,
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	rcm_pix_in_if.sink    pix_in,
	rcm_pix_out_if.source pix_out,
	rcm_cfg_if.sink       cfg
);

	localparam int SUM_W = COEF_WIDTH + rcm_pkg::CHAN_W + 4;
	localparam int ROWS  = rcm_pkg::ROWS;
	localparam int TERMS = rcm_pkg::NUM_TERMS;
	localparam logic [COEF_WIDTH-1:0] ONE_COEF = COEF_WIDTH'(64'd1 << COEF_FRAC_BITS);

	logic [ROWS-1:0][rcm_pkg::REG_W-1:0]        row_q;
	logic [TERMS-1:0][ROWS-1:0][COEF_WIDTH-1:0] coef;
	logic [TERMS:0]                             valid_c;
	logic [TERMS:0]                             ready_c;
	rcm_pkg::pix_t [TERMS:0]                    pix_c;
	logic [TERMS:0][ROWS-1:0][SUM_W-1:0]        sum_c;

	// row registers, identity after reset
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				row_q[r] <= rcm_pkg::REG_W'(ONE_COEF) << (COEF_WIDTH * r);
			end
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				rcm_pkg::CFG_RED_ROW:   row_q[0] <= cfg.data[rcm_pkg::REG_W-1:0];
				rcm_pkg::CFG_GREEN_ROW: row_q[1] <= cfg.data[rcm_pkg::REG_W-1:0];
				rcm_pkg::CFG_BLUE_ROW:  row_q[2] <= cfg.data[rcm_pkg::REG_W-1:0];
				rcm_pkg::CFG_ALPHA_ROW: row_q[3] <= cfg.data[rcm_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficient taps per column
	for (genvar k = 0; k < TERMS; k++) begin : g_tap
		for (genvar r = 0; r < ROWS; r++) begin : g_row
			assign coef[k][r] = row_q[r][COEF_WIDTH*k +: COEF_WIDTH];
		end
	end

	// head of the chain
	assign valid_c[0]     = pix_in.valid;
	assign pix_in.ready   = ready_c[0];
	assign pix_c[0].red   = pix_in.red_in;
	assign pix_c[0].green = pix_in.green_in;
	assign pix_c[0].blue  = pix_in.blue_in;
	assign pix_c[0].alpha = pix_in.alpha_in;
	assign sum_c[0]       = '0;

	// column cells
	for (genvar k = 0; k < TERMS; k++) begin : g_cell
		rcm_cell #(
			.COEF_WIDTH(COEF_WIDTH),
			.SUM_W     (SUM_W),
			.TERM      (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_valid(valid_c[k]),
			.up_ready(ready_c[k]),
			.pix_up  (pix_c[k]),
			.sum_up  (sum_c[k]),
			.coef    (coef[k]),
			.dn_ready(ready_c[k+1]),
			.dn_valid(valid_c[k+1]),
			.pix_dn  (pix_c[k+1]),
			.sum_dn  (sum_c[k+1])
		);
	end

	// clamp and output register
	rcm_clamp #(
		.SUM_W         (SUM_W),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_clamp (
		.clk     (clk),
		.arst_n  (arst_n),
		.up_valid(valid_c[TERMS]),
		.up_ready(ready_c[TERMS]),
		.sum_up  (sum_c[TERMS]),
		.pix_out (pix_out)
	);

	// configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg.ready)
		else $error("cfg not ready");

	// an empty output register lets the whole chain take a pixel
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_out.valid |-> pix_in.ready)
		else $error("input blocked with empty output");

	// a red row write lands in the register
	a_red_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index == rcm_pkg::CFG_RED_ROW
		|=> row_q[0] == $past(cfg.data[rcm_pkg::REG_W-1:0]))
		else $error("red row write lost");

	// a full chain of valid cells with a stalled receiver holds input off
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&valid_c[TERMS:1]) && pix_out.valid && !pix_out.ready |-> !pix_in.ready)
		else $error("input taken into a full chain");

endmodule

>>> tb/rgba_color_matrix_core_tb.sv
// self-checking testbench of the rgba 4x5 color matrix core
module rgba_color_matrix_core_tb;
	import rcm_pkg::*;

	localparam int COEF_W      = 12;
	localparam int COEF_FRAC   = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE      = 8;
	localparam int SEGMENTS    = 12;
	localparam int SEG_PIXELS  = 125;
	localparam int MAX_REPORTS = 10;

	// indexes past the alpha row, writes there are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum int {ROW_IDENTITY, ROW_MAX, ROW_MIN, ROW_ZERO, ROW_MIXED} row_kind_t;

	typedef struct {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} row_write_t;

	logic clk = 1'b0;
	logic arst_n;

	rcm_pix_in_if  pix_in ();
	rcm_pix_out_if pix_out ();
	rcm_cfg_if     cfg ();

	rgba_color_matrix_core #(
		.COEF_WIDTH     (COEF_W),
		.COEF_FRAC_BITS (COEF_FRAC)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	// matrix rows as the block should hold them
	logic [REG_W-1:0] row_coef [ROWS];

	pix_t       pixels_to_send [$];
	pix_t       expected_pix [$];
	row_write_t row_writes [$];

	int   send_idle_pct = 0;
	int   stall_pct = 0;
	int   error_count = 0;
	int   quiet_cycles = 0;
	pix_t next_pix;
	pix_t got_pix;
	pix_t want_pix;
	row_write_t next_write;

	logic [CFG_IDX_W-1:0] row_index [ROWS] =
		'{CFG_RED_ROW, CFG_GREEN_ROW, CFG_BLUE_ROW, CFG_ALPHA_ROW};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expected pixel: each row dotted with (R, G, B, A, 255), clamped, fraction dropped
	function automatic pix_t matrix_pixel(pix_t p);
		longint               chan [NUM_TERMS];
		longint               sum;
		logic signed [COEF_W-1:0] c;
		logic [CHAN_W-1:0]    res [ROWS];
		chan[0] = longint'(p.red);
		chan[1] = longint'(p.green);
		chan[2] = longint'(p.blue);
		chan[3] = longint'(p.alpha);
		chan[4] = longint'(BIAS_CHAN);
		for (int r = 0; r < ROWS; r++) begin
			sum = 0;
			for (int k = 0; k < NUM_TERMS; k++) begin
				c = row_coef[r][COEF_W*k +: COEF_W];
				sum += longint'(c) * chan[k];
			end
			if (sum <= 0)
				res[r] = '0;
			else if ((sum >> COEF_FRAC) > 255)
				res[r] = CHAN_MAX;
			else
				res[r] = sum[COEF_FRAC +: CHAN_W];
		end
		return pix_t'({res[0], res[1], res[2], res[3]});
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		case ($urandom_range(7))
			0: return '0;
			1: return CHAN_MAX;
			default: return CHAN_W'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(5))
			0: return 12'h000;
			1: return 12'h7FF;
			2: return 12'h800;
			3: return 12'h100;
			4: return COEF_W'(int'($urandom_range(512)) - 256);
			default: return COEF_W'($urandom_range(4095));
		endcase
	endfunction

	// register value for row r; bits above the row always random
	function automatic logic [CFG_DATA_W-1:0] pick_row(row_kind_t kind, int r);
		logic [CFG_DATA_W-1:0] v;
		v = {$urandom, $urandom};
		for (int k = 0; k < NUM_TERMS; k++) begin
			case (kind)
				ROW_IDENTITY: v[COEF_W*k +: COEF_W] = (k == r) ? 12'h100 : 12'h000;
				ROW_MAX:      v[COEF_W*k +: COEF_W] = 12'h7FF;
				ROW_MIN:      v[COEF_W*k +: COEF_W] = 12'h800;
				ROW_ZERO:     v[COEF_W*k +: COEF_W] = 12'h000;
				default:      v[COEF_W*k +: COEF_W] = rand_coef();
			endcase
		end
		return v;
	endfunction

	task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		row_write_t w;
		w.index = idx;
		w.data = value;
		row_writes.push_back(w);
	endtask

	task automatic send_pixel(logic [CHAN_W-1:0] r, g, b, a);
		pixels_to_send.push_back(pix_t'({r, g, b, a}));
	endtask

	// poll on the falling edge so every clocked update of the step has landed
	task automatic wait_idle();
		while (pixels_to_send.size() != 0 || pix_in.valid || expected_pix.size() != 0 ||
				row_writes.size() != 0 || cfg.valid)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// load all four rows of one kind plus a dropped write
	task automatic load_rows(row_kind_t kind);
		for (int r = 0; r < ROWS; r++)
			write_row(row_index[r], pick_row(kind, r));
		write_row(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
			{$urandom, $urandom});
		wait_idle();
	endtask

	// register write driver, also tracks the expected row contents
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= '0;
			cfg.data <= '0;
			row_coef[0] = REG_W'(12'h100);
			row_coef[1] = REG_W'(12'h100) << COEF_W;
			row_coef[2] = REG_W'(12'h100) << (2 * COEF_W);
			row_coef[3] = REG_W'(12'h100) << (3 * COEF_W);
		end else begin
			if (cfg.valid && cfg.ready && cfg.index <= CFG_ALPHA_ROW)
				row_coef[cfg.index[1:0]] = cfg.data[REG_W-1:0];
			if (!cfg.valid || cfg.ready) begin
				if (row_writes.size() != 0) begin
					next_write = row_writes.pop_front();
					cfg.valid <= 1'b1;
					cfg.index <= next_write.index;
					cfg.data <= next_write.data;
				end else begin
					cfg.valid <= 1'b0;
				end
			end
		end
	end

	// source pixel driver, predicts each pixel at its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_in.valid <= 1'b0;
			pix_in.red_in <= '0;
			pix_in.green_in <= '0;
			pix_in.blue_in <= '0;
			pix_in.alpha_in <= '0;
		end else begin
			if (pix_in.valid && pix_in.ready)
				expected_pix.push_back(matrix_pixel(pix_t'({pix_in.red_in, pix_in.green_in,
					pix_in.blue_in, pix_in.alpha_in})));
			if (!pix_in.valid || pix_in.ready) begin
				if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pix = pixels_to_send.pop_front();
					pix_in.valid <= 1'b1;
					pix_in.red_in <= next_pix.red;
					pix_in.green_in <= next_pix.green;
					pix_in.blue_in <= next_pix.blue;
					pix_in.alpha_in <= next_pix.alpha;
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_out.ready <= 1'b0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				got_pix = pix_t'({pix_out.red_out, pix_out.green_out, pix_out.blue_out,
					pix_out.alpha_out});
				if (expected_pix.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result pixel %h", got_pix);
				end else begin
					want_pix = expected_pix.pop_front();
					if (got_pix.red !== want_pix.red || got_pix.green !== want_pix.green ||
							got_pix.blue !== want_pix.blue ||
							got_pix.alpha !== want_pix.alpha) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("pixel mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
								want_pix.red, want_pix.green, want_pix.blue, want_pix.alpha,
								got_pix.red, got_pix.green, got_pix.blue, got_pix.alpha);
					end
				end
			end
			pix_out.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
					(cfg.valid && cfg.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// identity after reset passes pixels through
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
		send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
		send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
		send_pixel(8'd1, 8'd2, 8'd3, 8'd4);
		wait_idle();

		// red: -1.0*R + 0.5*255 goes negative or truncates
		// green: 2.0*G saturates from 128 up
		// blue: 0.75*B truncates its fraction
		// alpha: about 8*A + 1*255 saturates
		// upper register bits set, spare indexes written and dropped
		write_row(CFG_RED_ROW,   {4'hF, 12'h080, 12'h000, 12'h000, 12'h000, 12'hF00});
		write_row(CFG_GREEN_ROW, {4'hA, 12'h000, 12'h000, 12'h000, 12'h200, 12'h000});
		write_row(CFG_BLUE_ROW,  {4'h5, 12'h000, 12'h000, 12'h0C0, 12'h000, 12'h000});
		write_row(CFG_ALPHA_ROW, {4'hC, 12'h101, 12'h7FF, 12'h000, 12'h000, 12'h000});
		write_row(CFG_SPARE_LO, {$urandom, $urandom});
		write_row(CFG_SPARE_HI, {$urandom, $urandom});
		wait_idle();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd200, 8'd100, 8'd255, 8'd1);
		send_pixel(8'd255, 8'd255, 8'd1, 8'd255);
		send_pixel(8'd1, 8'd128, 8'd3, 8'd127);
		send_pixel(8'd128, 8'd127, 8'd254, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
		wait_idle();

		// extreme coefficients
		load_rows(ROW_MAX);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		wait_idle();
		load_rows(ROW_MIN);
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		wait_idle();

		// random pixels, matrix and idling pattern change per segment
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			load_rows(seg < 4 ? row_kind_t'(seg) : ROW_MIXED);
			case (seg % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 58; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 58; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			for (int i = 0; i < SEG_PIXELS; i++)
				send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan());
			wait_idle();
		end

		send_idle_pct = 0;
		stall_pct = 0;
		repeat (20) @(negedge clk);
		if (error_count == 0 && expected_pix.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
